/* sv/sspr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspr_pkg
// Types, codes and CRC-16 helpers shared by the status packet receiver.
// ----------------------------------------------------------------------------
package sspr_pkg;

   // Header bytes
   localparam logic [7:0] SYNC_BYTE   = 8'hFF;
   localparam logic [7:0] MARK_BYTE   = 8'hFD;
   localparam logic [7:0] RSVD_BYTE   = 8'h00;
   localparam logic [7:0] STATUS_BYTE = 8'h55;

   // Framing constants
   localparam int unsigned HDR_BYTES    = 8;
   localparam int unsigned LEN_OVERHEAD = 7;
   localparam int unsigned MIN_TOTAL    = 10;
   localparam int unsigned MAX_ID       = 16;

   localparam logic [15:0] CRC_POLY = 16'h8005;

   // Verdict codes
   localparam logic [2:0] VERDICT_RECORDED  = 3'd0;
   localparam logic [2:0] VERDICT_BAD_ID    = 3'd1;
   localparam logic [2:0] VERDICT_CRC_ERR   = 3'd2;
   localparam logic [2:0] VERDICT_TOO_LONG  = 3'd3;
   localparam logic [2:0] VERDICT_TOO_SHORT = 3'd4;

   // Token kinds passed from the front end to the back end
   typedef enum logic [1:0] {
      TOK_START  = 2'd0,
      TOK_BODY   = 2'd1,
      TOK_REJECT = 2'd2
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   data;     // body byte, or length high byte on start
      logic         crc_en;   // body byte goes into the CRC
      logic         last;     // body byte closes the packet
      logic [7:0]   id;
      logic [2:0]   verdict;  // reject only
      logic [16:0]  total;
      logic [15:0]  crc;      // CRC over the header on start
   } tok_type;

   typedef struct packed {
      logic [7:0]  servo_id;
      logic [2:0]  verdict;
      logic [16:0] packet_length;
      logic [15:0] presence_mask;
      logic [15:0] received_crc;
      logic [15:0] computed_crc;
   } res_type;

   // One table entry of the MSB-first CRC-16
   function automatic logic [15:0] crc_byte_term(input logic [7:0] idx);
      logic [15:0] c;
      c = {idx, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // Advance the CRC by one byte
   function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
      return {c[7:0], 8'h00} ^ crc_byte_term(c[15:8] ^ b);
   endfunction

   // CRC after the fixed first four header bytes
   localparam logic [15:0] HDR_PREFIX_CRC =
      crc_step(crc_step(crc_step(crc_step(16'h0000, SYNC_BYTE), SYNC_BYTE),
                        MARK_BYTE), RSVD_BYTE);

endpackage

/* sv/servo_status_packet_receiver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_status_packet_receiver_core
// Status packet deframer with CRC-16 check and servo presence mask.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while full is low and gives one result
// per finished or rejected packet. The front end shifts each byte into the
// header window (or tags it as a packet byte) in the cycle of its transfer,
// a two-entry queue carries the tag to the back end, which does one CRC
// table step per CRC-covered byte, and the result lands in a two-entry
// output queue, from which it shows on the rsp_ ports. full rises only when
// both queues back up behind a stalled pop. Header CRC is built up one table
// step per byte while the header is still arriving. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module servo_status_packet_receiver_core #(
   parameter int BUF_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_servo_id,
   output logic [2:0]  rsp_verdict,
   output logic [16:0] rsp_packet_length,
   output logic [15:0] rsp_presence_mask,
   output logic [15:0] rsp_received_crc,
   output logic [15:0] rsp_computed_crc
);

   localparam int TOK_W = $bits(sspr_pkg::tok_type);
   localparam int RES_W = $bits(sspr_pkg::res_type);

   sspr_pkg::tok_type tok_in, tok_out;
   sspr_pkg::res_type res_in, res_out;
   logic              tok_push, tok_full, tok_empty, tok_pop;
   logic              res_push, res_full;
   logic              byte_xfer;

   assign byte_xfer = push && !full;
   assign full      = tok_full;

   // front end: header hunt and byte tagging
   sspr_front #(
      .BUF_BYTES (BUF_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (byte_xfer),
      .in_byte  (req_rx_byte),
      .tok_push (tok_push),
      .tok      (tok_in)
   );

   // queue between front and back
   sspr_fifo #(
      .WIDTH (TOK_W),
      .DEPTH (2)
   ) u_tok_q (
      .clock (clock),
      .reset (reset),
      .push  (tok_push),
      .full  (tok_full),
      .din   (tok_in),
      .pop   (tok_pop),
      .empty (tok_empty),
      .dout  (tok_out)
   );

   // back end: CRC, verdict and presence mask
   sspr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (!tok_empty),
      .tok       (tok_out),
      .tok_pop   (tok_pop),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res_in)
   );

   // result queue
   sspr_fifo #(
      .WIDTH (RES_W),
      .DEPTH (2)
   ) u_res_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .full  (res_full),
      .din   (res_in),
      .pop   (pop),
      .empty (empty),
      .dout  (res_out)
   );

   assign rsp_servo_id      = res_out.servo_id;
   assign rsp_verdict       = res_out.verdict;
   assign rsp_packet_length = res_out.packet_length;
   assign rsp_presence_mask = res_out.presence_mask;
   assign rsp_received_crc  = res_out.received_crc;
   assign rsp_computed_crc  = res_out.computed_crc;

endmodule

/* sv/sspr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspr_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module sspr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] dout
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign dout    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

/* sv/sspr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspr_front
// Header hunt and byte classification. Slides an eight-byte window, spots a
// status header, checks its length and tags each packet byte for the back end.
// ----------------------------------------------------------------------------
module sspr_front #(
   parameter int BUF_BYTES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,   // byte transfer this cycle
   input  logic [7:0]       in_byte,
   output logic             tok_push,
   output sspr_pkg::tok_type tok
);

   localparam int CNT_W = $clog2(BUF_BYTES + 1);

   // newest seven bytes; the compare looks at the window one byte ahead
   logic [7:0]       win_ff [1:7];
   logic [3:0]       fill_ff, fill_in;
   logic             in_pkt_ff, in_pkt_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [15:0]      p1_ff, p2_ff, p3_ff;   // partial header CRCs

   logic [CNT_W-1:0] seen_next;
   logic             hdr_match;
   logic [16:0]      hdr_total;
   logic [15:0]      hdr_crc;

   assign seen_next = seen_ff + 1'b1;
   assign hdr_total = {1'b0, win_ff[7], win_ff[6]} + 17'(sspr_pkg::LEN_OVERHEAD);
   assign hdr_crc   = sspr_pkg::crc_step(p3_ff, in_byte);

   // header compare on the window as it will be after this byte
   assign hdr_match = (fill_in == 4'(sspr_pkg::HDR_BYTES))
                   && (win_ff[1] == sspr_pkg::SYNC_BYTE)
                   && (win_ff[2] == sspr_pkg::SYNC_BYTE)
                   && (win_ff[3] == sspr_pkg::MARK_BYTE)
                   && (win_ff[4] == sspr_pkg::RSVD_BYTE)
                   && (in_byte   == sspr_pkg::STATUS_BYTE);

   assign fill_in = (fill_ff < 4'(sspr_pkg::HDR_BYTES)) ? fill_ff + 1'b1 : fill_ff;

   // classification
   always_comb begin
      in_pkt_in   = in_pkt_ff;
      seen_in     = seen_ff;
      total_in    = total_ff;
      tok_push    = 1'b0;
      tok.kind    = sspr_pkg::TOK_BODY;
      tok.data    = in_byte;
      tok.crc_en  = ({1'b0, seen_ff} + (CNT_W + 1)'(2)) < {1'b0, total_ff};
      tok.last    = (seen_next >= total_ff);
      tok.id      = win_ff[5];
      tok.verdict = sspr_pkg::VERDICT_RECORDED;
      tok.total   = hdr_total;
      tok.crc     = hdr_crc;
      if (in_valid) begin
         if (in_pkt_ff) begin
            tok_push = 1'b1;
            seen_in  = seen_next;
            if (tok.last) begin
               in_pkt_in = 1'b0;
            end
         end else if (hdr_match) begin
            tok_push = 1'b1;
            tok.data = win_ff[7];
            if (hdr_total < 17'(sspr_pkg::MIN_TOTAL)) begin
               tok.kind    = sspr_pkg::TOK_REJECT;
               tok.verdict = sspr_pkg::VERDICT_TOO_SHORT;
            end else if (hdr_total > 17'(BUF_BYTES)) begin
               tok.kind    = sspr_pkg::TOK_REJECT;
               tok.verdict = sspr_pkg::VERDICT_TOO_LONG;
            end else begin
               tok.kind  = sspr_pkg::TOK_START;
               in_pkt_in = 1'b1;
               seen_in   = CNT_W'(sspr_pkg::HDR_BYTES);
               total_in  = hdr_total[CNT_W-1:0];
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         in_pkt_ff <= 1'b0;
         seen_ff   <= '0;
         total_ff  <= '0;
      end else begin
         in_pkt_ff <= in_pkt_in;
         seen_ff   <= seen_in;
         total_ff  <= total_in;
         if (in_valid) begin
            if (in_pkt_ff || hdr_match) begin
               fill_ff <= '0;
            end else begin
               fill_ff <= fill_in;
            end
         end
      end
   end

   // window shift and partial header CRC line
   always_ff @(posedge clock) begin
      if (in_valid && !in_pkt_ff) begin
         for (int k = 1; k < 7; k++) begin
            win_ff[k] <= win_ff[k+1];
         end
         win_ff[7] <= in_byte;
         p1_ff     <= sspr_pkg::crc_step(sspr_pkg::HDR_PREFIX_CRC, in_byte);
         p2_ff     <= sspr_pkg::crc_step(p1_ff, in_byte);
         p3_ff     <= sspr_pkg::crc_step(p2_ff, in_byte);
      end
   end

`ifndef NO_ASSERTIONS
   a_seen_below_total: assert property (@(posedge clock) disable iff (reset)
      in_pkt_ff |-> (seen_ff < total_ff))
      else $error("byte count reached packet total inside a packet");

   a_total_in_range: assert property (@(posedge clock) disable iff (reset)
      in_pkt_ff |-> (total_ff >= CNT_W'(sspr_pkg::MIN_TOTAL)))
      else $error("packet in progress with a total below the minimum");

   a_start_from_hunt: assert property (@(posedge clock) disable iff (reset)
      (tok_push && tok.kind == sspr_pkg::TOK_START) |-> !in_pkt_ff ##1 in_pkt_ff)
      else $error("packet start not taken from hunt mode");
`endif

endmodule

/* sv/sspr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspr_back
// Packet execution. Runs the CRC over body bytes, checks the trailing CRC,
// keeps the presence mask and builds one result per finished or rejected packet.
// ----------------------------------------------------------------------------
module sspr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              tok_valid,
   input  sspr_pkg::tok_type tok,
   output logic              tok_pop,
   input  logic              res_full,
   output logic              res_push,
   output sspr_pkg::res_type res
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  last0_ff, last0_in;
   logic [7:0]  last1_ff, last1_in;
   logic [7:0]  id_ff, id_in;
   logic [16:0] total_ff, total_in;
   logic [15:0] mask_ff, mask_in;

   logic [15:0] rcrc;
   logic        id_ok;
   logic [3:0]  id_bit;

   assign tok_pop = tok_valid && !res_full;
   assign rcrc    = {tok.data, last1_ff};
   assign id_ok   = (id_ff >= 8'd1) && (id_ff <= 8'(sspr_pkg::MAX_ID));
   assign id_bit  = id_ff[3:0] - 4'd1;

   // token execution
   always_comb begin
      crc_in   = crc_ff;
      last0_in = last0_ff;
      last1_in = last1_ff;
      id_in    = id_ff;
      total_in = total_ff;
      mask_in  = mask_ff;
      res_push = 1'b0;
      res.servo_id      = id_ff;
      res.verdict       = sspr_pkg::VERDICT_RECORDED;
      res.packet_length = total_ff;
      res.presence_mask = mask_ff;
      res.received_crc  = rcrc;
      res.computed_crc  = crc_ff;
      if (tok_pop) begin
         case (tok.kind)
            sspr_pkg::TOK_START: begin
               crc_in   = tok.crc;
               last0_in = tok.data;
               last1_in = sspr_pkg::STATUS_BYTE;
               id_in    = tok.id;
               total_in = tok.total;
            end
            sspr_pkg::TOK_BODY: begin
               if (tok.crc_en) begin
                  crc_in = sspr_pkg::crc_step(crc_ff, tok.data);
               end
               last0_in = last1_ff;
               last1_in = tok.data;
               if (tok.last) begin
                  res_push = 1'b1;
                  if (rcrc != crc_ff) begin
                     res.verdict = sspr_pkg::VERDICT_CRC_ERR;
                  end else if (!id_ok) begin
                     res.verdict = sspr_pkg::VERDICT_BAD_ID;
                  end else begin
                     mask_in = mask_ff | (16'd1 << id_bit);
                  end
                  res.presence_mask = mask_in;
               end
            end
            sspr_pkg::TOK_REJECT: begin
               res_push          = 1'b1;
               res.servo_id      = tok.id;
               res.verdict       = tok.verdict;
               res.packet_length = tok.total;
               res.received_crc  = '0;
               res.computed_crc  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff   <= crc_in;
      last0_ff <= last0_in;
      last1_ff <= last1_in;
      id_ff    <= id_in;
      total_ff <= total_in;
   end

`ifndef NO_ASSERTIONS
   a_recorded_id: assert property (@(posedge clock) disable iff (reset)
      (res_push && res.verdict == sspr_pkg::VERDICT_RECORDED)
         |-> (res.servo_id >= 8'd1 && res.servo_id <= 8'(sspr_pkg::MAX_ID)
              && res.received_crc == res.computed_crc))
      else $error("recorded verdict without a valid id and matching crc");

   a_mask_sticky: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (($past(mask_ff) & ~mask_ff) == 16'd0))
      else $error("presence mask lost a bit");

   a_reject_zero_crc: assert property (@(posedge clock) disable iff (reset)
      (res_push && (res.verdict == sspr_pkg::VERDICT_TOO_LONG
                    || res.verdict == sspr_pkg::VERDICT_TOO_SHORT))
         |-> (res.received_crc == 16'd0 && res.computed_crc == 16'd0))
      else $error("length reject carries nonzero crc fields");
`endif

endmodule
